// File: rtl/tafn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafn_pkg
// Shared widths, types and codes for triangle assembly with face normals.
// ----------------------------------------------------------------------------
package tafn_pkg;

	localparam int POSITION_BITS = 32;
	localparam int INDEX_BITS    = 32;
	localparam int NORMAL_BITS   = 16;

	// Edge differences carry one bit more than a position.
	localparam int EDGE_BITS = 33;
	// Edge magnitudes after scaling are below 2^30.
	localparam int EMAG_BITS = 30;
	// Cross product magnitudes stay below 2^61.
	localparam int CMAG_BITS = 62;
	// Quotient bits of the normal division, one above the normal width.
	localparam int QUO_BITS  = NORMAL_BITS + 1;
	// Triangles held between the assembly side and the normal side.
	localparam int TQ_DEPTH  = 2;

	localparam logic [NORMAL_BITS-1:0] MAXN = {1'b0, {(NORMAL_BITS-1){1'b1}}};

	typedef enum logic [1:0] {
		MODE_LIST  = 2'd0,
		MODE_STRIP = 2'd1,
		MODE_FAN   = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [POSITION_BITS-1:0] x;
		logic signed [POSITION_BITS-1:0] y;
		logic signed [POSITION_BITS-1:0] z;
		logic [INDEX_BITS-1:0]           idx;
	} vertex_t;

	typedef struct packed {
		vertex_t v0;
		vertex_t v1;
		vertex_t v2;
	} tri_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tq_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_CROSS,
		ST_ABS,
		ST_NORM,
		ST_SQUARE,
		ST_SQRT,
		ST_DMUL,
		ST_DADD,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	// Sign-extended coordinate of a vertex, selected by axis.
	function automatic logic signed [EDGE_BITS-1:0] coord(vertex_t v, logic [1:0] axis);
		logic signed [EDGE_BITS-1:0] r;
		case (axis)
			2'd0:    r = EDGE_BITS'(v.x);
			2'd1:    r = EDGE_BITS'(v.y);
			default: r = EDGE_BITS'(v.z);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tafn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafn_if
// Channel interfaces: vertex input, vertex output and mode write.
// ----------------------------------------------------------------------------
interface tafn_vtx_if;
	import tafn_pkg::*;
	logic                            valid;
	logic                            ready;
	logic signed [POSITION_BITS-1:0] pos_x;
	logic signed [POSITION_BITS-1:0] pos_y;
	logic signed [POSITION_BITS-1:0] pos_z;
	logic [INDEX_BITS-1:0]           source_index;
	logic                            first_of_primitive;
	modport source (output valid, pos_x, pos_y, pos_z, source_index, first_of_primitive,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, source_index, first_of_primitive,
		output ready);
endinterface

interface tafn_out_if;
	import tafn_pkg::*;
	logic                            valid;
	logic                            ready;
	logic signed [POSITION_BITS-1:0] out_x;
	logic signed [POSITION_BITS-1:0] out_y;
	logic signed [POSITION_BITS-1:0] out_z;
	logic signed [NORMAL_BITS-1:0]   normal_x;
	logic signed [NORMAL_BITS-1:0]   normal_y;
	logic signed [NORMAL_BITS-1:0]   normal_z;
	logic [INDEX_BITS-1:0]           out_source_index;
	logic                            last_of_triangle;
	modport source (output valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
		out_source_index, last_of_triangle, input ready);
	modport sink (input valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
		out_source_index, last_of_triangle, output ready);
endinterface

interface tafn_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/tafn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafn_front
// Assembles incoming vertices into triangles by the primitive mode.
// ----------------------------------------------------------------------------
module tafn_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	tafn_vtx_if.sink                  in_vtx,
	tafn_cfg_if.sink                  cfg,
	input  wire tafn_pkg::tq_status_t tq_st,
	output logic                      tq_push,
	output tafn_pkg::tri_t            tq_data
);
	import tafn_pkg::*;

	logic [1:0] mode_q;
	logic [1:0] seen_q;
	logic       par_q;
	vertex_t    h0_q, h1_q, anchor_q;

	logic       accept, chain, emit, par_cur;
	logic [1:0] seen_cur, seen_d;
	logic       par_d;
	vertex_t    cur;

	// Mode register; the user must write it only while the block is idle, the block itself does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LIST;
		end else if (cfg.valid) begin
			mode_q <= cfg.data;
		end
	end

	// A word is taken whenever the triangle queue has room.
	assign in_vtx.ready = !tq_st.full;
	assign accept       = in_vtx.valid && in_vtx.ready;

	// Assembly decisions for the incoming vertex.
	always_comb begin
		cur.x    = in_vtx.pos_x;
		cur.y    = in_vtx.pos_y;
		cur.z    = in_vtx.pos_z;
		cur.idx  = in_vtx.source_index;
		seen_cur = in_vtx.first_of_primitive ? 2'd0 : seen_q;
		par_cur  = in_vtx.first_of_primitive ? 1'b0 : par_q;
		chain    = (mode_q == MODE_STRIP) || (mode_q == MODE_FAN);
		emit     = (seen_cur == 2'd2);
		par_d    = par_cur;
		tq_data  = '{v0: h0_q, v1: h1_q, v2: cur};
		if (chain) begin
			seen_d = emit ? seen_cur : seen_cur + 2'd1;
		end else begin
			seen_d = emit ? 2'd0 : seen_cur + 2'd1;
		end
		if (mode_q == MODE_STRIP) begin
			if (par_cur) begin
				tq_data = '{v0: h0_q, v1: cur, v2: h1_q};
			end
			if (emit) begin
				par_d = ~par_cur;
			end
		end else if (mode_q == MODE_FAN) begin
			tq_data = '{v0: h1_q, v1: cur, v2: anchor_q};
		end
		tq_push = accept && emit;
	end

	// Assembly state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
			par_q  <= 1'b0;
		end else if (accept) begin
			seen_q <= seen_d;
			par_q  <= par_d;
		end
	end

	// Vertex history and fan anchor.
	always_ff @(posedge clk) begin
		if (accept) begin
			h0_q <= h1_q;
			h1_q <= cur;
			if (seen_cur == 2'd0) begin
				anchor_q <= cur;
			end
		end
	end

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3) else $error("vertex count left its range");

endmodule
`default_nettype wire

// File: rtl/tafn_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafn_fifo
// Short triangle queue between the assembly side and the normal side.
// ----------------------------------------------------------------------------
module tafn_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tq_push,
	input  wire tafn_pkg::tri_t  tq_wdata,
	input  wire logic            tq_pop,
	output tafn_pkg::tri_t       tq_rdata,
	output tafn_pkg::tq_status_t tq_st
);
	import tafn_pkg::*;

	localparam int PW = $clog2(TQ_DEPTH);

	tri_t           mem_q [TQ_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;

	assign tq_st.full  = (cnt_q == (PW+1)'(TQ_DEPTH));
	assign tq_st.empty = (cnt_q == '0);
	assign tq_rdata    = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (tq_push) begin
				wr_q <= (wr_q == PW'(TQ_DEPTH-1)) ? '0 : wr_q + PW'(1);
			end
			if (tq_pop) begin
				rd_q <= (rd_q == PW'(TQ_DEPTH-1)) ? '0 : rd_q + PW'(1);
			end
			if (tq_push && !tq_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (!tq_push && tq_pop) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (tq_push) begin
			mem_q[wr_q] <= tq_wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		tq_push |-> !tq_st.full) else $error("triangle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		tq_pop |-> !tq_st.empty) else $error("triangle queue underflow");

endmodule
`default_nettype wire

// File: rtl/tafn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafn_back
// Computes the unit face normal of a triangle and emits its three vertices.
// ----------------------------------------------------------------------------
module tafn_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tafn_pkg::tri_t       tq_rdata,
	input  wire tafn_pkg::tq_status_t tq_st,
	output logic                      tq_pop,
	tafn_out_if.source                out_vtx
);
	import tafn_pkg::*;

	back_state_t state_q, state_d;
	tri_t        tri_q;

	logic [2:0][EMAG_BITS-1:0]   ea_q, eb_q;
	logic [2:0]                  sa_q, sb_q;
	logic [2:0][63:0]            cr_q;
	logic [2:0][CMAG_BITS-1:0]   cu_q;
	logic [2:0]                  cs_q;
	logic [63:0]                 prod_q, sum_q;
	logic [63:0]                 rs_q, rr_q, rb_q;
	logic [31:0]                 len_q;
	logic [63:0]                 rem_q;
	logic [QUO_BITS-1:0]         quo_q;
	logic [2:0][NORMAL_BITS-1:0] nrm_q;
	logic [4:0]                  cnt_q;
	logic [1:0]                  k_q;

	logic [2:0][EMAG_BITS-1:0]   ea_d, eb_d;
	logic [2:0]                  sa_d, sb_d;
	logic [31:0]                 mul_a, mul_b;
	logic [63:0]                 mul_p;
	logic                        mul_neg;
	logic [63:0]                 sq_t, den_sh;
	logic                        sq_hit, div_hit;
	logic [QUO_BITS-1:0]         quo_d;
	logic [NORMAL_BITS-1:0]      q_clamp;
	logic                        c_zero, c_big, c_small;
	logic [1:0]                  cr_sel, nrm_sel;
	vertex_t                     ov;

	// Cross component being built, and normal component being finished.
	assign cr_sel  = 2'((cnt_q - 5'd1) >> 1);
	assign nrm_sel = 2'd2 - k_q;

	// Edge vectors scaled so their largest magnitude is below 2^30.
	always_comb begin
		logic signed [EDGE_BITS-1:0] d1, d2;
		logic [2:0][EDGE_BITS-1:0]   m1, m2;
		logic [EDGE_BITS-1:0]        o1, o2;
		for (int i = 0; i < 3; i++) begin
			d1 = coord(tri_q.v1, 2'(i)) - coord(tri_q.v0, 2'(i));
			d2 = coord(tri_q.v2, 2'(i)) - coord(tri_q.v0, 2'(i));
			sa_d[i] = d1[EDGE_BITS-1];
			sb_d[i] = d2[EDGE_BITS-1];
			m1[i] = d1[EDGE_BITS-1] ? EDGE_BITS'(-d1) : EDGE_BITS'(d1);
			m2[i] = d2[EDGE_BITS-1] ? EDGE_BITS'(-d2) : EDGE_BITS'(d2);
		end
		o1 = m1[0] | m1[1] | m1[2];
		o2 = m2[0] | m2[1] | m2[2];
		for (int i = 0; i < 3; i++) begin
			if (o1[32]) ea_d[i] = m1[i][32:3];
			else if (o1[31]) ea_d[i] = m1[i][31:2];
			else if (o1[30]) ea_d[i] = m1[i][30:1];
			else ea_d[i] = m1[i][29:0];
			if (o2[32]) eb_d[i] = m2[i][32:3];
			else if (o2[31]) eb_d[i] = m2[i][31:2];
			else if (o2[30]) eb_d[i] = m2[i][30:1];
			else eb_d[i] = m2[i][29:0];
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		if (state_q == ST_CROSS) begin
			unique case (cnt_q)
				5'd0: begin mul_a = 32'(ea_q[1]); mul_b = 32'(eb_q[2]);
					mul_neg = sa_q[1] ^ sb_q[2]; end
				5'd1: begin mul_a = 32'(ea_q[2]); mul_b = 32'(eb_q[1]);
					mul_neg = ~(sa_q[2] ^ sb_q[1]); end
				5'd2: begin mul_a = 32'(ea_q[2]); mul_b = 32'(eb_q[0]);
					mul_neg = sa_q[2] ^ sb_q[0]; end
				5'd3: begin mul_a = 32'(ea_q[0]); mul_b = 32'(eb_q[2]);
					mul_neg = ~(sa_q[0] ^ sb_q[2]); end
				5'd4: begin mul_a = 32'(ea_q[0]); mul_b = 32'(eb_q[1]);
					mul_neg = sa_q[0] ^ sb_q[1]; end
				5'd5: begin mul_a = 32'(ea_q[1]); mul_b = 32'(eb_q[0]);
					mul_neg = ~(sa_q[1] ^ sb_q[0]); end
				default: ;
			endcase
		end else if (state_q == ST_SQUARE) begin
			mul_a = cu_q[cnt_q[1:0]][31:0];
			mul_b = cu_q[cnt_q[1:0]][31:0];
		end else if (state_q == ST_DMUL) begin
			mul_a = cu_q[k_q][31:0];
			mul_b = 32'({MAXN, 1'b0});
		end
		mul_p = mul_a * mul_b;
	end

	// Normalization tests, square root step and division step.
	always_comb begin
		c_zero  = (cu_q[0] == '0) && (cu_q[1] == '0) && (cu_q[2] == '0);
		c_big   = |{cu_q[0][CMAG_BITS-1:31], cu_q[1][CMAG_BITS-1:31],
			cu_q[2][CMAG_BITS-1:31]};
		c_small = ~|{cu_q[0][CMAG_BITS-1:30], cu_q[1][CMAG_BITS-1:30],
			cu_q[2][CMAG_BITS-1:30]};
		sq_t    = rr_q + rb_q;
		sq_hit  = (rs_q >= sq_t);
		den_sh  = {31'd0, len_q, 1'b0} << cnt_q;
		div_hit = (rem_q >= den_sh);
		quo_d   = {quo_q[QUO_BITS-2:0], div_hit};
		q_clamp = (quo_d > QUO_BITS'(MAXN)) ? MAXN : quo_d[NORMAL_BITS-1:0];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		tq_pop        = 1'b0;
		out_vtx.valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!tq_st.empty) begin
					tq_pop  = 1'b1;
					state_d = ST_EDGE;
				end
			end
			ST_EDGE:   state_d = ST_CROSS;
			ST_CROSS:  if (cnt_q == 5'd6) state_d = ST_ABS;
			ST_ABS:    state_d = ST_NORM;
			ST_NORM: begin
				if (c_zero) state_d = ST_EMIT;
				else if (!c_big && !c_small) state_d = ST_SQUARE;
			end
			ST_SQUARE: if (cnt_q == 5'd3) state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == 5'd31) state_d = ST_DMUL;
			ST_DMUL:   state_d = ST_DADD;
			ST_DADD:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) state_d = (k_q == 2'd2) ? ST_EMIT : ST_DMUL;
			end
			ST_EMIT: begin
				out_vtx.valid = 1'b1;
				if (out_vtx.ready && k_q == 2'd2) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			k_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					k_q   <= '0;
				end
				ST_CROSS, ST_SQUARE, ST_SQRT: begin
					cnt_q <= (state_d == state_q) ? cnt_q + 5'd1 : 5'd0;
				end
				ST_DADD: cnt_q <= 5'(QUO_BITS - 1);
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (out_vtx.ready) begin
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tri_q <= tq_rdata;
			end
			ST_EDGE: begin
				ea_q <= ea_d;
				eb_q <= eb_d;
				sa_q <= sa_d;
				sb_q <= sb_d;
			end
			ST_CROSS: begin
				// Product of this step, summed into its component next step.
				prod_q <= mul_neg ? -mul_p : mul_p;
				if (cnt_q != '0) begin
					if (cnt_q[0]) cr_q[cr_sel] <= prod_q;
					else cr_q[cr_sel] <= cr_q[cr_sel] + prod_q;
				end
			end
			ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					cs_q[i] <= cr_q[i][63];
					cu_q[i] <= cr_q[i][63] ? CMAG_BITS'(-cr_q[i]) : CMAG_BITS'(cr_q[i]);
				end
			end
			ST_NORM: begin
				// One bit of shift a cycle until the largest lies in [2^30, 2^31).
				if (c_zero) begin
					nrm_q <= {NORMAL_BITS'(0), MAXN, NORMAL_BITS'(0)};
				end else if (c_big) begin
					for (int i = 0; i < 3; i++) cu_q[i] <= cu_q[i] >> 1;
				end else if (c_small) begin
					for (int i = 0; i < 3; i++) cu_q[i] <= cu_q[i] << 1;
				end
			end
			ST_SQUARE: begin
				prod_q <= mul_p;
				if (cnt_q == 5'd1) sum_q <= prod_q;
				else if (cnt_q == 5'd2) sum_q <= sum_q + prod_q;
				if (cnt_q == 5'd3) begin
					rs_q <= sum_q + prod_q;
					rr_q <= '0;
					rb_q <= 64'd1 << 62;
				end
			end
			ST_SQRT: begin
				// One result bit a cycle.
				if (sq_hit) begin
					rs_q <= rs_q - sq_t;
					rr_q <= (rr_q >> 1) + rb_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				rb_q <= rb_q >> 2;
				if (cnt_q == 5'd31) begin
					len_q <= sq_hit ? 32'((rr_q >> 1) + rb_q) : 32'(rr_q >> 1);
				end
			end
			ST_DMUL: prod_q <= mul_p;
			ST_DADD: begin
				rem_q <= prod_q + 64'(len_q);
				quo_q <= '0;
			end
			ST_DIV: begin
				// Restoring division, one quotient bit a cycle.
				if (div_hit) rem_q <= rem_q - den_sh;
				quo_q <= quo_d;
				if (cnt_q == '0) begin
					nrm_q[nrm_sel] <= cs_q[k_q] ? -q_clamp : q_clamp;
				end
			end
			default: ;
		endcase
	end

	// Output word, one vertex of the held triangle at a time.
	always_comb begin
		case (k_q)
			2'd0:    ov = tri_q.v0;
			2'd1:    ov = tri_q.v1;
			default: ov = tri_q.v2;
		endcase
		out_vtx.out_x            = ov.x;
		out_vtx.out_y            = ov.y;
		out_vtx.out_z            = ov.z;
		out_vtx.out_source_index = ov.idx;
		out_vtx.normal_x         = nrm_q[2];
		out_vtx.normal_y         = nrm_q[1];
		out_vtx.normal_z         = nrm_q[0];
		out_vtx.last_of_triangle = (k_q == 2'd2);
	end

	a_norm_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQUARE |-> !c_big && !c_small)
		else $error("cross product not normalized before squaring");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> len_q[31:30] != 2'b00)
		else $error("normal length below its lower bound");
	a_pop_edge: assert property (@(posedge clk) disable iff (!arst_n)
		tq_pop |=> state_q == ST_EDGE) else $error("popped triangle not taken");

endmodule
`default_nettype wire

// File: rtl/triangle_assembly_face_normals_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_assembly_face_normals_top
// Triangle assembly (list, strip, fan) with flat unit face normals.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  in_vtx   | in  | vertex position Q16.16, source index, primitive start
//  out_vtx  | out | vertex position, face normal Q1.15, index, last flag
//  cfg      | in  | primitive mode (list, strip, fan)
//
// A vertex is taken whenever the triangle queue has room. A triangle passes
// in the normal unit through the one-bit normalizing shifter, the serial
// square root and three serial divisions; a degenerate one skips them all.
// Its three vertices then leave one per cycle while the output is ready.
// Up to two triangles wait in the queue, so assembly keeps taking vertices
// while the normal unit works or the output stalls. Reset clears the mode,
// the assembly counters and the queue.
module triangle_assembly_face_normals_top (
	input wire logic    clk,
	input wire logic    arst_n,
	tafn_vtx_if.sink    in_vtx,
	tafn_out_if.source  out_vtx,
	tafn_cfg_if.sink    cfg
);
	import tafn_pkg::*;

	tri_t       push_tri, pop_tri;
	logic       push, pop;
	tq_status_t tq_st;

	// Assembly side.
	tafn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vtx  (in_vtx),
		.cfg     (cfg),
		.tq_st   (tq_st),
		.tq_push (push),
		.tq_data (push_tri)
	);

	// Triangle queue.
	tafn_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.tq_push  (push),
		.tq_wdata (push_tri),
		.tq_pop   (pop),
		.tq_rdata (pop_tri),
		.tq_st    (tq_st)
	);

	// Normal side.
	tafn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tq_rdata (pop_tri),
		.tq_st    (tq_st),
		.tq_pop   (pop),
		.out_vtx  (out_vtx)
	);

endmodule
`default_nettype wire

// File: dv/tafn_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tafn_checker
// Watches the vertex, output and mode channels of the triangle assembly
// block, predicts every emitted vertex with its face normal and compares.
// ----------------------------------------------------------------------------
module tafn_checker (
	input wire logic   clk,
	input wire logic   arst_n,
	tafn_vtx_if.sink   in_vtx,
	tafn_out_if.sink   out_vtx,
	tafn_cfg_if.sink   cfg,
	output int         fail_count,
	output int         pending_count
);
	import tafn_pkg::*;

	typedef struct packed {
		logic signed [POSITION_BITS-1:0] x;
		logic signed [POSITION_BITS-1:0] y;
		logic signed [POSITION_BITS-1:0] z;
		logic signed [NORMAL_BITS-1:0]   nx;
		logic signed [NORMAL_BITS-1:0]   ny;
		logic signed [NORMAL_BITS-1:0]   nz;
		logic [INDEX_BITS-1:0]           idx;
		logic                            last;
	} out_word_t;

	out_word_t expected_words[$];

	// Assembly state kept by the predictor.
	logic [1:0] mode_r;
	vertex_t    hist[2];
	vertex_t    anchor;
	int         seen;
	bit         parity;

	function automatic longint unsigned mag64(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Shrinks an edge until every component magnitude is below 2^30.
	function automatic void shrink_edge(ref longint e[3]);
		longint unsigned u[3];
		longint unsigned m;
		for (int i = 0; i < 3; i++) u[i] = mag64(e[i]);
		m = (u[0] > u[1]) ? u[0] : u[1];
		if (u[2] > m) m = u[2];
		while (m >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) u[i] = u[i] >> 1;
			m = m >> 1;
		end
		for (int i = 0; i < 3; i++) e[i] = (e[i] < 0) ? -longint'(u[i]) : longint'(u[i]);
	endfunction

	function automatic void face_normal(vertex_t a, vertex_t b, vertex_t c,
		output logic signed [NORMAL_BITS-1:0] n[3]);
		longint e1[3], e2[3], cr[3], pa[3], pb[3], pc[3];
		longint unsigned u[3], m, sum, len, q, maxn;
		maxn = MAXN;
		pa = '{a.x, a.y, a.z};
		pb = '{b.x, b.y, b.z};
		pc = '{c.x, c.y, c.z};
		for (int i = 0; i < 3; i++) begin
			e1[i] = pb[i] - pa[i];
			e2[i] = pc[i] - pa[i];
		end
		shrink_edge(e1);
		shrink_edge(e2);
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		for (int i = 0; i < 3; i++) u[i] = mag64(cr[i]);
		m = (u[0] > u[1]) ? u[0] : u[1];
		if (u[2] > m) m = u[2];
		// A degenerate triangle gets the up vector.
		if (m == 0) begin
			n[0] = '0;
			n[1] = MAXN;
			n[2] = '0;
			return;
		end
		while (m >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++) u[i] = u[i] >> 1;
			m = m >> 1;
		end
		while (m < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) u[i] = u[i] << 1;
			m = m << 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum += u[i] * u[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (u[i] * maxn * 2 + len) / (2 * len);
			if (q > maxn) q = maxn;
			n[i] = (cr[i] < 0) ? -NORMAL_BITS'(q) : NORMAL_BITS'(q);
		end
	endfunction

	function automatic void queue_triangle(vertex_t a, vertex_t b, vertex_t c);
		logic signed [NORMAL_BITS-1:0] n[3];
		vertex_t v[3];
		out_word_t w;
		face_normal(a, b, c, n);
		v = '{a, b, c};
		for (int k = 0; k < 3; k++) begin
			w.x = v[k].x;
			w.y = v[k].y;
			w.z = v[k].z;
			w.nx = n[0];
			w.ny = n[1];
			w.nz = n[2];
			w.idx = v[k].idx;
			w.last = (k == 2);
			expected_words = {expected_words, w};
		end
	endfunction

	// Assembles one accepted vertex into triangles.
	function automatic void take_vertex(vertex_t cur, logic first);
		if (first) begin
			seen = 0;
			parity = 0;
		end
		if (seen == 0) anchor = cur;
		if (mode_r == MODE_STRIP || mode_r == MODE_FAN) begin
			if (seen >= 2) begin
				if (mode_r == MODE_STRIP) begin
					if (parity) queue_triangle(hist[0], cur, hist[1]);
					else queue_triangle(hist[0], hist[1], cur);
					parity = !parity;
				end else begin
					queue_triangle(hist[1], cur, anchor);
				end
			end else begin
				seen++;
			end
		end else if (seen >= 2) begin
			queue_triangle(hist[0], hist[1], cur);
			seen = 0;
		end else begin
			seen++;
		end
		hist[0] = hist[1];
		hist[1] = cur;
	endfunction

	// Samples all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		vertex_t v;
		out_word_t got, want;
		if (!arst_n) begin
			mode_r = MODE_LIST;
			hist[0] = '0;
			hist[1] = '0;
			anchor = '0;
			seen = 0;
			parity = 0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (cfg.valid && cfg.ready) mode_r = cfg.data;
			if (in_vtx.valid && in_vtx.ready) begin
				v.x = in_vtx.pos_x;
				v.y = in_vtx.pos_y;
				v.z = in_vtx.pos_z;
				v.idx = in_vtx.source_index;
				take_vertex(v, in_vtx.first_of_primitive);
			end
			if (out_vtx.valid && out_vtx.ready) begin
				got = '{out_vtx.out_x, out_vtx.out_y, out_vtx.out_z, out_vtx.normal_x,
					out_vtx.normal_y, out_vtx.normal_z, out_vtx.out_source_index,
					out_vtx.last_of_triangle};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected output word %h", $time, got);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: output word mismatch, expected %h, actual %h",
							$time, want, got);
						fail_count++;
					end
				end
			end
		end
		pending_count = expected_words.size();
	end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Drives vertices in list, strip and fan mode with random idling on both
// sides, lets the checker predict and compare, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import tafn_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 440;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   stall_cycles;
	bit   quiet_phase;
	int   idle_count;

	tafn_vtx_if in_vtx();
	tafn_out_if out_vtx();
	tafn_cfg_if cfg();

	triangle_assembly_face_normals_top dut (
		.clk(clk), .arst_n(arst_n), .in_vtx(in_vtx), .out_vtx(out_vtx), .cfg(cfg));

	tafn_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_vtx(in_vtx), .out_vtx(out_vtx), .cfg(cfg),
		.fail_count(fail_count), .pending_count(pending_count));

	initial begin
		clk = 0;
		forever #10 clk = !clk;
	end

	// Output back-pressure in random bursts, none in the final phase.
	initial begin
		int burst;
		out_vtx.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				out_vtx.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 4) - 1;
				out_vtx.ready <= 1'b0;
			end else begin
				out_vtx.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which nothing is accepted.
	always @(posedge clk) begin
		if ((in_vtx.valid && in_vtx.ready) || (out_vtx.valid && out_vtx.ready)
			|| (cfg.valid && cfg.ready))
			stall_cycles <= 0;
		else if (arst_n) begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 7) << 16;
			3: return $urandom & 32'h0003_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] idx, logic first);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			in_vtx.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_vtx.valid <= 1'b1;
		in_vtx.pos_x <= x;
		in_vtx.pos_y <= y;
		in_vtx.pos_z <= z;
		in_vtx.source_index <= idx;
		in_vtx.first_of_primitive <= first;
		@(posedge clk);
		while (!in_vtx.ready) @(posedge clk);
	endtask

	task automatic send_random(logic first);
		send_vertex(pick_coord(), pick_coord(), pick_coord(), $urandom, first);
	endtask

	// Drains, lets the block settle, then writes the mode.
	task automatic set_mode(logic [1:0] m);
		in_vtx.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= m;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [1:0] m;
		arst_n = 1'b0;
		quiet_phase = 0;
		in_vtx.valid <= 1'b0;
		in_vtx.pos_x <= '0;
		in_vtx.pos_y <= '0;
		in_vtx.pos_z <= '0;
		in_vtx.source_index <= '0;
		in_vtx.first_of_primitive <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.data <= MODE_LIST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed list: unit triangle, extreme corners, degenerate triangle.
		send_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
		send_vertex(32'h0001_0000, 32'h0, 32'h0, 32'hffff_ffff, 1'b0);
		send_vertex(32'h0, 32'h0001_0000, 32'h0, 32'h1, 1'b0);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h2, 1'b0);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h3, 1'b0);
		send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h4, 1'b0);
		send_vertex(32'h5, 32'h5, 32'h5, 32'h5, 1'b0);
		send_vertex(32'h5, 32'h5, 32'h5, 32'h6, 1'b0);
		send_vertex(32'ha, 32'ha, 32'ha, 32'h7, 1'b0);
		// A restart in the middle of a list triangle drops the partial one.
		send_random(1'b0);
		send_random(1'b1);
		send_random(1'b0);
		send_random(1'b0);

		// Directed strip, then fan, with a mode change inside a primitive.
		set_mode(MODE_STRIP);
		for (int i = 0; i < 5; i++) send_random(i == 0);
		set_mode(MODE_FAN);
		for (int i = 0; i < 5; i++) send_random(1'b0);
		set_mode(2'd3);
		for (int i = 0; i < 4; i++) send_random(1'b0);

		// Random primitives under a random mode.
		for (int n = 0; n < RANDOM_WORDS; ) begin
			int prim_len;
			if (n > RANDOM_WORDS - 60) quiet_phase = 1;
			if ($urandom_range(0, 3) == 0) begin
				m = 2'($urandom_range(0, 3));
				set_mode(m);
			end
			prim_len = $urandom_range(1, 9);
			for (int k = 0; k < prim_len; k++) begin
				send_random(k == 0 ? 1'b1 : ($urandom_range(0, 15) == 0));
				n++;
			end
		end

		in_vtx.valid <= 1'b0;
		@(posedge clk);
		idle_count = 0;
		while (pending_count != 0 && idle_count < 20000) begin
			@(posedge clk);
			idle_count++;
		end
		repeat (150) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
